// File: src/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants of the ultrasonic echo ranger
// Holds the word types of both channels, the stage-to-stage measurement word,
// configuration register indexes, status codes and ranging constants.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

    // Sensor lines and configuration port
    localparam int SENSOR_LINES = 3;
    localparam int SENSOR_COUNT_DEF = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_TIMEOUT    = 2'd0,
        CFG_FULL_BELOW = 2'd1,
        CFG_MID_BELOW  = 2'd2,
        CFG_LOW_BELOW  = 2'd3
    } t_cfg_idx;

    // Configuration reset values
    localparam logic [15:0] TIMEOUT_RST    = 16'd30000;
    localparam logic [11:0] FULL_BELOW_RST = 12'd5;
    localparam logic [11:0] MID_BELOW_RST  = 12'd10;
    localparam logic [11:0] LOW_BELOW_RST  = 12'd15;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TIMEOUT   = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;

    // Tank levels
    localparam logic [1:0] LVL_EMPTY = 2'd0;
    localparam logic [1:0] LVL_LOW   = 2'd1;
    localparam logic [1:0] LVL_MID   = 2'd2;
    localparam logic [1:0] LVL_FULL  = 2'd3;

    // Trigger timing in ticks
    localparam logic [15:0] TRIG_LOW_TICKS  = 16'd2;
    localparam logic [15:0] TRIG_HIGH_TICKS = 16'd10;

    // Distance = (width * 2.2/58 + 2.5) in 16-bit fraction fixed point
    localparam int          PROD_W      = 28;
    localparam logic [27:0] DIST_MUL    = 28'd2486;
    localparam logic [27:0] DIST_OFFSET = 28'd163840;

    typedef struct packed {
        logic       cmd;
        logic [1:0] sensor;
        logic [2:0] echo_lines;
    } t_uer_in;

    typedef struct packed {
        logic [2:0]  trig_lines;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  status;
        logic [11:0] range_cm;
        logic [1:0]  tank_level;
    } t_uer_out;

    // Measurement word between sequencer and ranging stage
    typedef struct packed {
        logic [2:0]  trig_lines;
        logic        busy;
        logic        done;
        logic [1:0]  status;
        logic [15:0] width;
    } t_uer_meas;

    typedef struct packed {
        logic [11:0] full_below_cm;
        logic [11:0] mid_below_cm;
        logic [11:0] low_below_cm;
    } t_uer_thresh;

endpackage

`default_nettype wire

// File: src/uer_ctrl.sv
// ----------------------------------------------------------------------------
// uer_ctrl: trigger and echo sequencer
// Advances the measurement phase once per accepted tick word and registers
// the trigger lines, busy/done flags, status and echo pulse width.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_ctrl
    import uer_pkg::*;
#(
    parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [15:0] i_timeout_ticks,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_uer_in     i_in_data,
    output logic             o_meas_valid,
    input  wire logic        i_meas_ready,
    output t_uer_meas        o_meas
);

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_TRIG_LOW  = 3'd1,
        PH_TRIG_HIGH = 3'd2,
        PH_WAIT_RISE = 3'd3,
        PH_WAIT_FALL = 3'd4
    } t_phase;

    localparam logic [2:0] SENSOR_LIMIT = 3'(SENSOR_COUNT);

    t_phase      r_phase, n_phase;
    logic [15:0] r_phase_ticks, n_phase_ticks;
    logic [15:0] r_pulse_ticks, n_pulse_ticks;
    logic [1:0]  r_active, n_active;
    logic        r_meas_valid;
    t_uer_meas   r_meas, n_meas;
    logic        accept;
    logic [2:0]  echo_sh;
    logic        echo_hi;

    assign o_in_ready   = !r_meas_valid || i_meas_ready;
    assign accept       = i_in_valid && o_in_ready;
    assign o_meas_valid = r_meas_valid;
    assign o_meas       = r_meas;

    // Pick the active sensor's echo bit
    assign echo_sh = i_in_data.echo_lines >> r_active;
    assign echo_hi = echo_sh[0];

    // Next phase, counters and measurement word for this tick
    always_comb begin
        n_phase       = r_phase;
        n_phase_ticks = r_phase_ticks;
        n_pulse_ticks = r_pulse_ticks;
        n_active      = r_active;
        n_meas        = '0;
        n_meas.status = ST_OK;
        n_meas.busy   = 1'b1;
        case (r_phase)
            PH_TRIG_LOW: begin
                if (r_phase_ticks + 16'd1 >= TRIG_LOW_TICKS) begin
                    n_phase       = PH_TRIG_HIGH;
                    n_phase_ticks = '0;
                end else begin
                    n_phase_ticks = r_phase_ticks + 16'd1;
                end
            end
            PH_TRIG_HIGH: begin
                n_meas.trig_lines = 3'b001 << r_active;
                if (r_phase_ticks + 16'd1 >= TRIG_HIGH_TICKS) begin
                    n_phase       = PH_WAIT_RISE;
                    n_phase_ticks = '0;
                end else begin
                    n_phase_ticks = r_phase_ticks + 16'd1;
                end
            end
            PH_WAIT_RISE: begin
                if (echo_hi) begin
                    n_phase       = PH_WAIT_FALL;
                    n_phase_ticks = '0;
                    n_pulse_ticks = 16'd1;
                end else if (r_phase_ticks >= i_timeout_ticks) begin
                    n_meas.busy   = 1'b0;
                    n_meas.done   = 1'b1;
                    n_meas.status = ST_TIMEOUT;
                    n_phase       = PH_IDLE;
                    n_phase_ticks = '0;
                    n_pulse_ticks = '0;
                end else begin
                    n_phase_ticks = r_phase_ticks + 16'd1;
                end
            end
            PH_WAIT_FALL: begin
                if (!echo_hi) begin
                    n_meas.busy   = 1'b0;
                    n_meas.done   = 1'b1;
                    n_meas.width  = r_pulse_ticks;
                    n_phase       = PH_IDLE;
                    n_phase_ticks = '0;
                    n_pulse_ticks = '0;
                end else if (r_phase_ticks >= i_timeout_ticks) begin
                    n_meas.busy   = 1'b0;
                    n_meas.done   = 1'b1;
                    n_meas.status = ST_TIMEOUT;
                    n_phase       = PH_IDLE;
                    n_phase_ticks = '0;
                    n_pulse_ticks = '0;
                end else begin
                    n_phase_ticks = r_phase_ticks + 16'd1;
                    if (r_pulse_ticks != 16'hFFFF) begin
                        n_pulse_ticks = r_pulse_ticks + 16'd1;
                    end
                end
            end
            default: begin
                // Idle, or an unknown phase treated as idle
                n_phase = PH_IDLE;
                if (!i_in_data.cmd) begin
                    n_meas.busy = 1'b0;
                end else if ({1'b0, i_in_data.sensor} >= SENSOR_LIMIT) begin
                    n_meas.busy   = 1'b0;
                    n_meas.done   = 1'b1;
                    n_meas.status = ST_BAD_INDEX;
                    n_phase_ticks = '0;
                    n_pulse_ticks = '0;
                end else begin
                    // Start tick is the first trigger-low tick
                    n_active      = i_in_data.sensor;
                    n_phase       = PH_TRIG_LOW;
                    n_phase_ticks = 16'd1;
                    n_pulse_ticks = '0;
                end
            end
        endcase
    end

    // Hold state and the measurement word; advance on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_phase_ticks <= '0;
            r_pulse_ticks <= '0;
            r_active      <= '0;
            r_meas_valid  <= 1'b0;
            r_meas        <= '0;
        end else begin
            if (accept) begin
                r_phase       <= n_phase;
                r_phase_ticks <= n_phase_ticks;
                r_pulse_ticks <= n_pulse_ticks;
                r_active      <= n_active;
                r_meas        <= n_meas;
                r_meas_valid  <= 1'b1;
            end else if (i_meas_ready) begin
                r_meas_valid  <= 1'b0;
            end
        end
    end

    // A finished measurement never reports busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_meas_valid && r_meas.done |-> !r_meas.busy)
        else $error("done and busy set in the same word");

    // Status is only nonzero on a finishing word
    a_status_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_meas_valid && !r_meas.done |-> r_meas.status == ST_OK)
        else $error("status set without done");

    // At most one trigger line is driven
    a_one_trigger: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_meas_valid |-> $onehot0(r_meas.trig_lines))
        else $error("more than one trigger line driven");

    // Pulse count is clear outside a pulse and nonzero during one
    a_pulse_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_pulse_ticks == '0)
        else $error("pulse count left over in idle");

    a_pulse_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_WAIT_FALL |-> r_pulse_ticks != '0)
        else $error("pulse count zero while timing the echo");

endmodule

`default_nettype wire

// File: src/uer_range.sv
// ----------------------------------------------------------------------------
// uer_range: distance conversion and tank level output stage
// Scales the echo pulse width to centimeters, classes it against the three
// thresholds and holds the result word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_range
    import uer_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_uer_thresh i_thresh,
    input  wire logic        i_meas_valid,
    output logic             o_meas_ready,
    input  wire t_uer_meas   i_meas,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_uer_out         o_out_data
);

    logic [PROD_W-1:0] prod;
    logic [11:0]       cm_value;
    logic [1:0]        level;
    t_uer_out          n_out;
    t_uer_out          r_out;
    logic              r_out_valid;

    assign o_meas_ready = !r_out_valid || i_out_ready;
    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out;

    // Scale width; the top 12 bits of the product never exceed 2488 cm
    assign prod     = PROD_W'(i_meas.width) * DIST_MUL + DIST_OFFSET;
    assign cm_value = prod[PROD_W-1:16];

    // Class the distance, nearest threshold first
    always_comb begin
        priority if (cm_value < i_thresh.full_below_cm) begin
            level = LVL_FULL;
        end else if (cm_value < i_thresh.mid_below_cm) begin
            level = LVL_MID;
        end else if (cm_value < i_thresh.low_below_cm) begin
            level = LVL_LOW;
        end else begin
            level = LVL_EMPTY;
        end
    end

    // Build the result word; distance and level only on a good finish
    always_comb begin
        n_out            = '0;
        n_out.trig_lines = i_meas.trig_lines;
        n_out.busy_res   = i_meas.busy;
        n_out.done_res   = i_meas.done;
        n_out.status     = i_meas.status;
        if (i_meas.done && i_meas.status == ST_OK) begin
            n_out.range_cm   = cm_value;
            n_out.tank_level = level;
        end
    end

    // Hold the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_meas_ready) begin
            r_out_valid <= i_meas_valid;
        end
    end

    // Load the result word
    always_ff @(posedge i_clk) begin
        if (o_meas_ready && i_meas_valid) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// File: src/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: trigger/echo timing and ranging for three sensors
// Each input word is one microsecond tick carrying a start command, a sensor
// index and the sampled echo lines. Each accepted word gives exactly one
// result word: trigger lines, busy/done flags, status, distance and level.
//
// Input and output channels use valid/ready. A result passes the sequencer
// register, then the ranging register, after its word is accepted, and
// one word is taken every cycle while the receiver keeps ready high.
// When the receiver stalls, the output register and the sequencer register
// fill and o_in_ready drops; no word is lost or repeated.
// The configuration port writes timeout_ticks (index 0), full_below_cm (1),
// mid_below_cm (2) or low_below_cm (3), one per write; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Reset (synchronous, active low) returns the sequencer to idle, clears both
// pipeline valid flags and loads the configuration defaults: timeout 30000,
// thresholds 5, 10 and 15 cm.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger
    import uer_pkg::*;
#(
    parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_uer_in               i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_uer_out                   o_out_data
);

    logic [15:0] r_timeout_ticks;
    t_uer_thresh r_thresh;
    logic        meas_valid;
    logic        meas_ready;
    t_uer_meas   meas;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks        <= TIMEOUT_RST;
            r_thresh.full_below_cm <= FULL_BELOW_RST;
            r_thresh.mid_below_cm  <= MID_BELOW_RST;
            r_thresh.low_below_cm  <= LOW_BELOW_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TIMEOUT:    r_timeout_ticks        <= i_cfg_wdata[15:0];
                CFG_FULL_BELOW: r_thresh.full_below_cm <= i_cfg_wdata[11:0];
                CFG_MID_BELOW:  r_thresh.mid_below_cm  <= i_cfg_wdata[11:0];
                CFG_LOW_BELOW:  r_thresh.low_below_cm  <= i_cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    uer_ctrl #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_timeout_ticks (r_timeout_ticks),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_data       (i_in_data),
        .o_meas_valid    (meas_valid),
        .i_meas_ready    (meas_ready),
        .o_meas          (meas)
    );

    uer_range u_range (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_thresh     (r_thresh),
        .i_meas_valid (meas_valid),
        .o_meas_ready (meas_ready),
        .i_meas       (meas),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

`default_nettype wire
